// File: rtl/lome_pkg.sv
// Shared types, constants and helper functions for the linked order move engine.
package lome_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int LINK_W    = $clog2(MAX_ITEMS + 1);
    localparam int FIELD_W   = 7;

    localparam logic [1:0] FUNC_INIT        = 2'd0;
    localparam logic [1:0] FUNC_MOVE_BEFORE = 2'd1;
    localparam logic [1:0] FUNC_MOVE_AFTER  = 2'd2;
    localparam logic [1:0] FUNC_DUMP        = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [FIELD_W-1:0] item;
        logic [FIELD_W-1:0] target;
    } cmd_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] item_number;
        logic               last;
    } rsp_item_t;

    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_IN   = 2'd1,
        RD_TGT  = 2'd2,
        RD_IDX  = 2'd3
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE   = 3'd0,
        WR_INIT   = 3'd1,
        WR_UNLINK = 3'd2,
        WR_LINK1  = 3'd3,
        WR_LINK2  = 3'd4
    } wr_sel_t;

    typedef enum logic [1:0] {
        IDX_HOLD = 2'd0,
        IDX_ZERO = 2'd1,
        IDX_INC  = 2'd2,
        IDX_NEXT = 2'd3
    } idx_op_t;

    typedef struct packed {
        logic    load;
        rd_sel_t rd;
        wr_sel_t wr;
        idx_op_t idx;
        logic    idx_one;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] in_func;
        logic       in_move_ok;
        logic       sweep_last;
        logic       scan_last;
        logic       walk_last;
        logic       pred_zero;
        logic       out_free;
    } ctl_sts_t;

    // Link values past the table read as the end marker.
    function automatic logic [LINK_W-1:0] slot(input logic [FIELD_W-1:0] v);
        logic [LINK_W-1:0] r;
        r = (v <= FIELD_W'(MAX_ITEMS)) ? LINK_W'(v) : '0;
        return r;
    endfunction

    function automatic logic [LINK_W-1:0] eff_count(input logic [FIELD_W-1:0] v);
        logic [LINK_W-1:0] r;
        if (v == '0)
            r = LINK_W'(1);
        else if (v > FIELD_W'(MAX_ITEMS))
            r = LINK_W'(MAX_ITEMS);
        else
            r = LINK_W'(v);
        return r;
    endfunction

    function automatic logic [LINK_W-1:0] pred_init(input logic [LINK_W-1:0] i,
                                                    input logic [LINK_W-1:0] c);
        logic [LINK_W-1:0] r;
        r = (i != '0 && i <= c) ? i - LINK_W'(1) : '0;
        return r;
    endfunction

    function automatic logic [LINK_W-1:0] succ_init(input logic [LINK_W-1:0] i,
                                                    input logic [LINK_W-1:0] c);
        logic [LINK_W-1:0] r;
        r = (i != '0 && i < c) ? i + LINK_W'(1) : '0;
        return r;
    endfunction

endpackage

// File: rtl/lome_ctrl.sv
// Sequencer for init sweep, move, head scan and dump walk.
module lome_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  lome_pkg::ctl_sts_t sts,
    output lome_pkg::ctl_cmd_t ctl
);

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_INIT      = 10'b00_0000_0010,
        ST_MV_UNLINK = 10'b00_0000_0100,
        ST_MV_RD_Y   = 10'b00_0000_1000,
        ST_MV_LINK1  = 10'b00_0001_0000,
        ST_MV_LINK2  = 10'b00_0010_0000,
        ST_SC_RD     = 10'b00_0100_0000,
        ST_SC_CHK    = 10'b00_1000_0000,
        ST_WK_RD     = 10'b01_0000_0000,
        ST_WK_EMIT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign cmd_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        ctl         = '0;
        ctl.rd      = lome_pkg::RD_NONE;
        ctl.wr      = lome_pkg::WR_NONE;
        ctl.idx     = lome_pkg::IDX_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load = 1'b1;
                    unique case (sts.in_func)
                        lome_pkg::FUNC_INIT:
                        begin
                            ctl.idx    = lome_pkg::IDX_ZERO;
                            state_next = ST_INIT;
                        end
                        lome_pkg::FUNC_MOVE_BEFORE, lome_pkg::FUNC_MOVE_AFTER:
                        begin
                            if (sts.in_move_ok)
                            begin
                                ctl.rd     = lome_pkg::RD_IN;
                                state_next = ST_MV_UNLINK;
                            end
                        end
                        lome_pkg::FUNC_DUMP:
                        begin
                            ctl.idx     = lome_pkg::IDX_ZERO;
                            ctl.idx_one = 1'b1;
                            ctl.cnt_clr = 1'b1;
                            state_next  = ST_SC_RD;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT:
            begin
                ctl.wr  = lome_pkg::WR_INIT;
                ctl.idx = lome_pkg::IDX_INC;
                if (sts.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_MV_UNLINK:
            begin
                ctl.wr     = lome_pkg::WR_UNLINK;
                state_next = ST_MV_RD_Y;
            end
            ST_MV_RD_Y:
            begin
                ctl.rd     = lome_pkg::RD_TGT;
                state_next = ST_MV_LINK1;
            end
            ST_MV_LINK1:
            begin
                ctl.wr     = lome_pkg::WR_LINK1;
                state_next = ST_MV_LINK2;
            end
            ST_MV_LINK2:
            begin
                ctl.wr     = lome_pkg::WR_LINK2;
                state_next = ST_IDLE;
            end
            ST_SC_RD:
            begin
                ctl.rd     = lome_pkg::RD_IDX;
                state_next = ST_SC_CHK;
            end
            ST_SC_CHK:
            begin
                // read the successor of the candidate now; used only if it is the head
                ctl.rd = lome_pkg::RD_IDX;
                if (sts.pred_zero)
                    state_next = ST_WK_EMIT;
                else if (sts.scan_last)
                    state_next = ST_IDLE;
                else
                begin
                    ctl.idx    = lome_pkg::IDX_INC;
                    state_next = ST_SC_RD;
                end
            end
            ST_WK_RD:
            begin
                ctl.rd     = lome_pkg::RD_IDX;
                state_next = ST_WK_EMIT;
            end
            ST_WK_EMIT:
            begin
                if (sts.out_free)
                begin
                    ctl.emit = 1'b1;
                    if (sts.walk_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        ctl.idx     = lome_pkg::IDX_NEXT;
                        ctl.cnt_inc = 1'b1;
                        state_next  = ST_WK_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: rtl/lome_dpath.sv
// Link tables, command and walk registers, and the result register.
module lome_dpath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  lome_pkg::cmd_item_t              cmd,
    input  logic                             cfg_valid,
    input  logic [lome_pkg::FIELD_W-1:0]     cfg_data,
    input  lome_pkg::ctl_cmd_t               ctl,
    output lome_pkg::ctl_sts_t               sts,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output lome_pkg::rsp_item_t              rsp
);

    localparam int LW    = lome_pkg::LINK_W;
    localparam int DEPTH = lome_pkg::MAX_ITEMS + 1;

    logic [lome_pkg::FIELD_W-1:0] item_count_reg;
    lome_pkg::cmd_item_t          cmd_reg;
    logic [LW-1:0]                idx_reg;
    logic [LW-1:0]                cnt_reg;
    logic                         rsp_valid_reg;
    lome_pkg::rsp_item_t          rsp_reg;

    logic [LW-1:0] pred_mem [DEPTH];
    logic [LW-1:0] succ_mem [DEPTH];
    logic [DEPTH-1:0] pred_vld_reg;
    logic [DEPTH-1:0] succ_vld_reg;

    logic [LW-1:0] pred_raw_reg;
    logic [LW-1:0] succ_raw_reg;
    logic          pred_hit_reg;
    logic          succ_hit_reg;
    logic [LW-1:0] raddr_reg;

    logic [LW-1:0] cnt_eff;
    logic [LW-1:0] raddr;
    logic          re;
    logic [LW-1:0] rd_pred;
    logic [LW-1:0] rd_succ;
    logic [LW-1:0] nx;
    logic          walk_end;
    logic          p_we;
    logic          s_we;
    logic [LW-1:0] p_waddr;
    logic [LW-1:0] p_wdata;
    logic [LW-1:0] s_waddr;
    logic [LW-1:0] s_wdata;
    logic [LW-1:0] x;
    logic [LW-1:0] y;
    logic [LW-1:0] in_x;
    logic [LW-1:0] in_y;
    logic          move_before;

    assign cnt_eff = lome_pkg::eff_count(item_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_count_reg <= lome_pkg::FIELD_W'(lome_pkg::MAX_ITEMS);
        else if (cfg_valid)
            item_count_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            cmd_reg <= cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            case (ctl.idx)
                lome_pkg::IDX_ZERO: idx_reg <= ctl.idx_one ? LW'(1) : '0;
                lome_pkg::IDX_INC:  idx_reg <= idx_reg + LW'(1);
                lome_pkg::IDX_NEXT: idx_reg <= nx;
                default:            idx_reg <= idx_reg;
            endcase
            if (ctl.cnt_clr)
                cnt_reg <= '0;
            else if (ctl.cnt_inc)
                cnt_reg <= cnt_reg + LW'(1);
        end
    end

    // read port, shared address for both tables
    assign in_x = lome_pkg::slot(cmd.item);
    assign x    = lome_pkg::slot(cmd_reg.item);
    assign y    = lome_pkg::slot(cmd_reg.target);
    assign in_y = lome_pkg::slot(cmd.target);

    always_comb
    begin
        re    = 1'b1;
        raddr = idx_reg;
        case (ctl.rd)
            lome_pkg::RD_IN:  raddr = in_x;
            lome_pkg::RD_TGT: raddr = y;
            lome_pkg::RD_IDX: raddr = idx_reg;
            default:          re    = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            pred_raw_reg <= pred_mem[raddr];
            succ_raw_reg <= succ_mem[raddr];
            pred_hit_reg <= pred_vld_reg[raddr];
            succ_hit_reg <= succ_vld_reg[raddr];
            raddr_reg    <= raddr;
        end
    end

    // unwritten entries read as the power-up order
    assign rd_pred = pred_hit_reg ? pred_raw_reg
                   : lome_pkg::pred_init(raddr_reg, LW'(lome_pkg::MAX_ITEMS));
    assign rd_succ = succ_hit_reg ? succ_raw_reg
                   : lome_pkg::succ_init(raddr_reg, LW'(lome_pkg::MAX_ITEMS));

    // write port
    assign move_before = (cmd_reg.func == lome_pkg::FUNC_MOVE_BEFORE);

    always_comb
    begin
        p_we    = 1'b1;
        s_we    = 1'b1;
        p_waddr = '0;
        p_wdata = '0;
        s_waddr = '0;
        s_wdata = '0;
        case (ctl.wr)
            lome_pkg::WR_INIT:
            begin
                p_waddr = idx_reg;
                p_wdata = lome_pkg::pred_init(idx_reg, cnt_eff);
                s_waddr = idx_reg;
                s_wdata = lome_pkg::succ_init(idx_reg, cnt_eff);
            end
            lome_pkg::WR_UNLINK:
            begin
                s_waddr = lome_pkg::slot(lome_pkg::FIELD_W'(rd_pred));
                s_wdata = lome_pkg::slot(lome_pkg::FIELD_W'(rd_succ));
                p_waddr = s_wdata;
                p_wdata = s_waddr;
            end
            lome_pkg::WR_LINK1:
            begin
                if (move_before)
                begin
                    s_waddr = lome_pkg::slot(lome_pkg::FIELD_W'(rd_pred));
                    s_wdata = x;
                    p_waddr = x;
                    p_wdata = s_waddr;
                end
                else
                begin
                    s_waddr = x;
                    s_wdata = lome_pkg::slot(lome_pkg::FIELD_W'(rd_succ));
                    p_waddr = s_wdata;
                    p_wdata = x;
                end
            end
            lome_pkg::WR_LINK2:
            begin
                if (move_before)
                begin
                    s_waddr = x;
                    s_wdata = y;
                    p_waddr = y;
                    p_wdata = x;
                end
                else
                begin
                    s_waddr = y;
                    s_wdata = x;
                    p_waddr = x;
                    p_wdata = y;
                end
            end
            default:
            begin
                p_we = 1'b0;
                s_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
            pred_mem[p_waddr] <= p_wdata;
        if (s_we)
            succ_mem[s_waddr] <= s_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_vld_reg <= '0;
            succ_vld_reg <= '0;
        end
        else
        begin
            if (p_we)
                pred_vld_reg[p_waddr] <= 1'b1;
            if (s_we)
                succ_vld_reg[s_waddr] <= 1'b1;
        end
    end

    // dump walk
    assign nx       = lome_pkg::slot(lome_pkg::FIELD_W'(rd_succ));
    assign walk_end = (nx == '0) || ((cnt_reg + LW'(1)) >= cnt_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (ctl.emit)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            rsp_reg.item_number <= lome_pkg::FIELD_W'(idx_reg);
            rsp_reg.last        <= walk_end;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        sts.in_func    = cmd.func;
        sts.in_move_ok = (in_x != '0) && (cmd.item <= lome_pkg::FIELD_W'(cnt_eff))
                       && (in_y != '0) && (cmd.target <= lome_pkg::FIELD_W'(cnt_eff))
                       && (cmd.item != cmd.target);
        sts.sweep_last = (idx_reg == LW'(lome_pkg::MAX_ITEMS));
        sts.pred_zero  = (rd_pred == '0);
        sts.out_free   = !rsp_valid_reg || rsp_ready;
        // scan: candidate is the last one; walk: this result ends the dump
        sts.scan_last  = (idx_reg >= cnt_eff);
        sts.walk_last  = walk_end;
    end

endmodule

// File: rtl/linked_order_move_engine.sv
// Top level of the linked order move engine: controller plus link-table datapath.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  cmd     | in        | cmd_valid / cmd_ready  | lome_pkg::cmd_item_t (func, item, target)
//  rsp     | out       | rsp_valid / rsp_ready  | lome_pkg::rsp_item_t (item_number, last)
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_data = item_count (always ready)
//
// Sequencing: a move reads the item's links, unlinks it, reads the target's links and
// then writes two link pairs; a rejected move is taken and dropped in idle. An init
// writes one link entry per cycle over all 65 entries. A dump reads and checks each
// head candidate in turn, then reads and emits each result. The steps follow from the
// single write port and single registered read port of each link table.
// Reset: asynchronous, active low; the links read as the order 1..64 until written.
// Stalls: results sit in an output register; the walk pauses while it is full, and a
// new command is taken while the final result of a dump still waits.
module linked_order_move_engine
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  lome_pkg::cmd_item_t          cmd,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output lome_pkg::rsp_item_t          rsp,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lome_pkg::FIELD_W-1:0] cfg_data
);

    lome_pkg::ctl_cmd_t ctl;
    lome_pkg::ctl_sts_t sts;

    // register writes land in the next cycle
    assign cfg_ready = 1'b1;

    lome_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    lome_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// File: tb/lome_order_checker.sv
// Checker for the linked order move engine: mirrors the link tables and compares dump output.
module lome_order_checker
    import lome_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic               cmd_ready,
    input  cmd_item_t          cmd,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  rsp_item_t          rsp,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [FIELD_W-1:0] cfg_data,
    output int unsigned        pending,
    output int unsigned        errors
);

    logic [FIELD_W-1:0] pred_tbl [0:MAX_ITEMS];
    logic [FIELD_W-1:0] succ_tbl [0:MAX_ITEMS];
    logic [FIELD_W-1:0] count_reg;
    rsp_item_t          order_q [$];
    int unsigned        err_cnt;

    // links past the table end read as the end marker
    function automatic int link_slot(input int v);
        return (v <= MAX_ITEMS) ? v : 0;
    endfunction

    function automatic int live_count();
        if (count_reg == '0)
            return 1;
        if (count_reg > FIELD_W'(MAX_ITEMS))
            return MAX_ITEMS;
        return int'(count_reg);
    endfunction

    function automatic void rebuild_order();
        int c;
        c = live_count();
        for (int i = 0; i <= MAX_ITEMS; i++)
        begin
            pred_tbl[i] = (i >= 1 && i <= c) ? FIELD_W'(i - 1) : '0;
            succ_tbl[i] = (i >= 1 && i < c) ? FIELD_W'(i + 1) : '0;
        end
    endfunction

    function automatic void link_pair(input int a, input int b);
        int sa;
        int sb;
        sa = link_slot(a);
        sb = link_slot(b);
        succ_tbl[sa] = FIELD_W'(sb);
        pred_tbl[sb] = FIELD_W'(sa);
    endfunction

    function automatic void relink_item(input logic [1:0] f, input int x, input int y);
        int c;
        c = live_count();
        if (x == 0 || x > c || y == 0 || y > c || x == y)
            return;
        link_pair(int'(pred_tbl[x]), int'(succ_tbl[x]));
        if (f == FUNC_MOVE_AFTER)
        begin
            link_pair(x, int'(succ_tbl[y]));
            link_pair(y, x);
        end
        else
        begin
            link_pair(int'(pred_tbl[y]), x);
            link_pair(x, y);
        end
    endfunction

    // head is the first item with no predecessor; walk stops at the end marker or at count results
    function automatic void walk_order();
        int        c;
        int        h;
        int        n;
        int        nx;
        bit        done;
        rsp_item_t e;
        c = live_count();
        h = 1;
        while (h <= c && pred_tbl[h] != '0)
            h++;
        if (h > c)
            return;
        n    = 0;
        done = 1'b0;
        while (!done)
        begin
            nx            = link_slot(int'(succ_tbl[h]));
            done          = (nx == 0) || (n + 1 >= c);
            e.item_number = FIELD_W'(h);
            e.last        = done;
            order_q.push_back(e);
            n++;
            h = nx;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg = FIELD_W'(MAX_ITEMS);
            rebuild_order();
            order_q.delete();
            err_cnt = 0;
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                count_reg = cfg_data;

            if (rsp_valid && rsp_ready)
            begin
                if (order_q.size() == 0)
                begin
                    $error("result with nothing expected: item_number %0d last %0d",
                           rsp.item_number, rsp.last);
                    err_cnt++;
                end
                else
                begin
                    if (rsp.item_number !== order_q[0].item_number)
                    begin
                        $error("item_number mismatch: expected %0d, got %0d",
                               order_q[0].item_number, rsp.item_number);
                        err_cnt++;
                    end
                    if (rsp.last !== order_q[0].last)
                    begin
                        $error("last mismatch: expected %0d, got %0d",
                               order_q[0].last, rsp.last);
                        err_cnt++;
                    end
                    void'(order_q.pop_front());
                end
            end

            if (cmd_valid && cmd_ready)
            begin
                case (cmd.func)
                    FUNC_INIT:        rebuild_order();
                    FUNC_MOVE_BEFORE,
                    FUNC_MOVE_AFTER:  relink_item(cmd.func, int'(cmd.item),
                                                  int'(cmd.target));
                    default:          walk_order();
                endcase
            end

            pending <= order_q.size();
            errors  <= err_cnt;
        end
    end

endmodule

// File: tb/linked_order_move_engine_tb.sv
// Testbench top for the linked order move engine: stimulus, result back-pressure and verdict.
module linked_order_move_engine_tb;

    import lome_pkg::*;

    // Fixed waits. SETTLE covers the longest command that returns nothing:
    // an init sweeps all 65 link entries, a headless dump scans all 64
    // candidates.
    localparam int SETTLE      = 200;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    cmd_item_t          cmd       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_item_t          rsp;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [FIELD_W-1:0] cfg_data  = '0;

    int unsigned        pending;
    int unsigned        errors;
    int unsigned        cycles;

    // per-phase switches: when set, that side runs with no idle cycles
    bit                 cmd_eager = 1'b0;
    bit                 rsp_eager = 1'b0;
    bit                 rsp_took  = 1'b0;
    int                 ready_hold = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    linked_order_move_engine i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lome_order_checker i_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    // ------------------------------------------------------------------
    // Result side back-pressure. After each accepted result a fresh stall
    // is drawn at random. While idle, ready also drops now and then so that
    // the first result of a dump can meet a stall as well.
    // ------------------------------------------------------------------
    always @(posedge clk)
        rsp_took <= rsp_valid && rsp_ready;

    always @(negedge clk)
    begin
        if (rsp_took)
            ready_hold = rsp_eager ? 0 : $urandom_range(0, 8);
        else if (!rsp_eager && ready_hold == 0 && $urandom_range(0, 7) == 0)
            ready_hold = $urandom_range(1, 8);
        if (ready_hold > 0)
        begin
            rsp_ready <= 1'b0;
            ready_hold--;
        end
        else
            rsp_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Command transaction. The gap before the item is drawn first; valid
    // stays high straight into the next item when that gap is zero, so it
    // is never lowered and raised within one step.
    // ------------------------------------------------------------------
    task automatic push_cmd(input logic [1:0] f, input int x, input int y);
        int        gap;
        cmd_item_t c;
        gap      = cmd_eager ? 0 : $urandom_range(0, 8);
        c.func   = f;
        c.item   = FIELD_W'(x);
        c.target = FIELD_W'(y);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
    endtask

    // Sender pause: drop valid and wait for every expected dump entry.
    task automatic hold_until_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    // Count register writes happen only with the engine idle: drain the
    // results, then let any init or headless dump still in flight finish.
    task automatic write_count(input int v);
        hold_until_drained();
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_data  <= FIELD_W'(v);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // One random phase at a given count setting. Mostly legal moves with
    // random operands, dumps often enough to observe the order, a few
    // inits, and some noise: out-of-range operands and self moves. Every
    // transaction sent counts toward the quota.
    // ------------------------------------------------------------------
    task automatic run_phase(input int cfg_value, input int quota);
        int         c;
        int         sent;
        int         r;
        int         x;
        int         y;
        logic [1:0] f;
        write_count(cfg_value);
        c         = (cfg_value == 0) ? 1 : (cfg_value > MAX_ITEMS) ? MAX_ITEMS : cfg_value;
        cmd_eager = ($urandom_range(0, 3) == 0);
        rsp_eager = ($urandom_range(0, 3) == 0);
        sent      = 0;
        // half the phases keep the stale links left by the old count
        if ($urandom_range(0, 1) == 1)
        begin
            push_cmd(FUNC_INIT, $urandom_range(0, 127), $urandom_range(0, 127));
            sent++;
        end
        while (sent < quota)
        begin
            if ($urandom_range(0, 39) == 0)
                hold_until_drained();
            r = $urandom_range(0, 99);
            f = $urandom_range(0, 1) ? FUNC_MOVE_AFTER : FUNC_MOVE_BEFORE;
            if (r < 4)
            begin
                f = FUNC_INIT;
                x = $urandom_range(0, 127);
                y = $urandom_range(0, 127);
            end
            else if (r < 20)
            begin
                f = FUNC_DUMP;
                x = $urandom_range(0, 127);
                y = $urandom_range(0, 127);
            end
            else if (r < 30)
            begin
                // full field range, mostly rejected operands
                x = $urandom_range(0, 127);
                y = $urandom_range(0, 127);
            end
            else if (r < 33)
            begin
                x = $urandom_range(1, c);
                y = x;
            end
            else
            begin
                x = $urandom_range(1, c);
                y = x;
                if (c > 1)
                begin
                    while (y == x)
                        y = $urandom_range(1, c);
                end
            end
            push_cmd(f, x, y);
            sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset order, moves at both ends, rejected operands.
        push_cmd(FUNC_DUMP,        0,   0);
        push_cmd(FUNC_MOVE_BEFORE, 64,  1);
        push_cmd(FUNC_MOVE_AFTER,  1,   64);
        push_cmd(FUNC_MOVE_AFTER,  2,   63);
        push_cmd(FUNC_MOVE_BEFORE, 0,   5);
        push_cmd(FUNC_MOVE_AFTER,  5,   0);
        push_cmd(FUNC_MOVE_BEFORE, 127, 3);
        push_cmd(FUNC_MOVE_AFTER,  3,   127);
        push_cmd(FUNC_MOVE_BEFORE, 65,  1);
        push_cmd(FUNC_MOVE_BEFORE, 7,   7);
        push_cmd(FUNC_DUMP,        127, 127);
        push_cmd(FUNC_INIT,        127, 127);
        push_cmd(FUNC_DUMP,        0,   0);
        // item 1 leaves the head; item 2 becomes the head
        push_cmd(FUNC_MOVE_AFTER,  1,   5);
        push_cmd(FUNC_DUMP,        0,   0);

        // Count 1 with item 1 still linked after 5: no head, dump is silent.
        write_count(1);
        push_cmd(FUNC_DUMP, 0, 0);
        // Zero saturates up to one: same silent dump.
        write_count(0);
        push_cmd(FUNC_DUMP, 0, 0);
        // Count 3 over stale links: the walk is cut off at three entries.
        write_count(3);
        push_cmd(FUNC_DUMP, 0, 0);
        push_cmd(FUNC_MOVE_BEFORE, 1, 2);
        push_cmd(FUNC_DUMP, 0, 0);
        // Above range saturates to the full table.
        write_count(127);
        push_cmd(FUNC_DUMP, 0, 0);
        push_cmd(FUNC_INIT, 0, 0);
        push_cmd(FUNC_DUMP, 0, 0);

        // Random phases across count settings, extremes included.
        run_phase(64, 50);
        run_phase(2, 30);
        run_phase(1, 15);
        run_phase($urandom_range(3, 63), 60);
        run_phase(127, 50);
        run_phase(0, 15);
        run_phase($urandom_range(65, 126), 45);
        run_phase(16, 55);
        run_phase(64, 60);
        run_phase($urandom_range(2, 64), 60);

        hold_until_drained();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/lome_pkg.sv
rtl/lome_ctrl.sv
rtl/lome_dpath.sv
rtl/linked_order_move_engine.sv
tb/lome_order_checker.sv
tb/linked_order_move_engine_tb.sv
